// ===== design/entity_ownership_table_unit_assert.svh =====
// Assertion macros shared by the entity ownership table RTL.
`ifndef ENTITY_OWNERSHIP_TABLE_UNIT_ASSERT_SVH
`define ENTITY_OWNERSHIP_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define EOT_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define EOT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/eot_pkg.sv =====
// Shared types and constants of the entity ownership table.
`timescale 1ns / 1ps
`default_nettype none

package eot_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int ID_W          = 64;
    localparam int CFG_W         = 16;
    localparam int OP_W          = 3;

    localparam int IN_DATA_W     = 2 * ID_W + CFG_W;
    localparam int OUT_DATA_W    = 24;

    // Command queue between front and back; depth must be a power of two
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE    = 3'd0,
        OP_RELEASE    = 3'd1,
        OP_LOCK       = 3'd2,
        OP_QUERY      = 3'd3,
        OP_GET_CONFIG = 3'd4,
        OP_SET_CONFIG = 3'd5,
        OP_OTHER      = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_ACQ_ELSEWHERE = 3'd1,
        ST_LOCK_REFUSED  = 3'd2,
        ST_UNKNOWN       = 3'd3,
        ST_BAD_ARGS      = 3'd4,
        ST_NOT_IMPL      = 3'd5,
        ST_REL_REFUSED   = 3'd6
    } t_status;

    typedef struct packed {
        t_op               op;
        logic              needs_scan;
        logic [ID_W-1:0]   target_entity;
        logic [ID_W-1:0]   controller_entity;
        logic [CFG_W-1:0]  config_value;
    } t_cmd;

    // One table row as held in the entry RAM
    typedef struct packed {
        logic              locked;
        logic              acquired;
        logic [ID_W-1:0]   owner;
        logic [ID_W-1:0]   id;
    } t_row;

    // Packed so that status lands in the lowest bits of the output word
    typedef struct packed {
        logic [CFG_W-1:0]  configuration;
        logic              is_locked;
        logic              is_acquired;
        t_status           status;
    } t_result;

    typedef struct packed {
        logic              exec;
        logic [CNT_W-1:0]  count;
    } t_back_stat;

endpackage

`default_nettype wire

// ===== design/eot_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module eot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/eot_front.sv =====
// Front end: accept command words, classify them and queue them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module eot_front import eot_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic [OP_W-1:0]       i_s_axis_tuser,
    output logic                  o_q_valid,
    output t_cmd                  o_q_cmd,
    input  logic                  i_q_ready
);

    t_cmd               cmd_in;
    logic               push;
    logic               pop;
    t_cmd               r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_CW-1:0] r_cnt;
    logic [QUEUE_CW-1:0] n_cnt;

    // Table commands need a scan; the configuration and unknown ones do not
    always_comb begin
        cmd_in.op                = t_op'(i_s_axis_tuser);
        cmd_in.needs_scan        = (i_s_axis_tuser <= OP_QUERY);
        cmd_in.target_entity     = i_s_axis_tdata[ID_W-1:0];
        cmd_in.controller_entity = i_s_axis_tdata[2*ID_W-1:ID_W];
        cmd_in.config_value      = i_s_axis_tdata[2*ID_W+CFG_W-1:2*ID_W];
    end

    assign o_s_axis_tready = (r_cnt != QUEUE_CW'(QUEUE_DEPTH));
    assign o_q_valid       = (r_cnt != '0);
    assign o_q_cmd         = r_q[r_rptr];
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign pop             = o_q_valid && i_q_ready;

    always_comb begin
        unique case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ===== design/eot_back.sv =====
// Back end: scan the entry RAM for the target, apply the command, hold the result word.
`timescale 1ns / 1ps
`default_nettype none

module eot_back import eot_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_q_ready,
    output logic        o_res_valid,
    output t_result     o_res,
    input  logic        i_res_ready,
    output t_back_stat  o_stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]              r_state;
    t_cmd                    r_cmd;
    logic [CNT_W-1:0]        r_addr;
    logic                    r_pend;
    logic [IDX_W-1:0]        r_pend_idx;
    logic                    r_found;
    logic [IDX_W-1:0]        r_hit_idx;
    t_row                    r_row;
    logic [CNT_W-1:0]        r_count;
    logic [CFG_W-1:0]        r_conf;
    logic                    r_out_valid;
    t_result                 r_out;

    logic [$bits(t_row)-1:0] ram_rdata;
    t_row                    rd_row;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    t_row                    ram_wrow;

    logic                    take;
    logic                    scan_hit;
    logic                    scan_done;
    logic                    issue;
    logic                    owned;
    logic                    add;
    logic                    cmd_we;
    logic [CFG_W-1:0]        n_conf;
    t_result                 n_res;

    eot_ram #(
        .WIDTH ($bits(t_row)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wrow),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_row    = t_row'(ram_rdata);
    assign o_q_ready = (r_state == S_IDLE) && !r_out_valid;
    assign take      = i_q_valid && o_q_ready;

    // Data of the entry issued last cycle is compared while the next one is read
    assign scan_hit  = (r_state == S_SCAN) && r_pend && (rd_row.id == r_cmd.target_entity);
    assign scan_done = scan_hit || ((r_state == S_SCAN) && !r_pend && (r_addr >= r_count));
    assign issue     = (r_state == S_SCAN) && !scan_hit && (r_addr < r_count);

    assign owned = r_row.acquired && (r_row.owner == r_cmd.controller_entity);

    always_comb begin
        n_res     = '0;
        cmd_we    = 1'b0;
        add       = 1'b0;
        n_conf    = r_conf;
        ram_wrow  = r_row;
        ram_waddr = r_found ? r_hit_idx : r_count[IDX_W-1:0];
        unique case (r_cmd.op)
            OP_ACQUIRE: begin
                if (!r_found) begin
                    if (r_count >= CNT_W'(TABLE_ENTRIES)) begin
                        n_res.status = ST_ACQ_ELSEWHERE;
                    end else begin
                        add               = 1'b1;
                        cmd_we            = 1'b1;
                        ram_wrow.locked   = 1'b0;
                        ram_wrow.acquired = 1'b1;
                        ram_wrow.owner    = r_cmd.controller_entity;
                        ram_wrow.id       = r_cmd.target_entity;
                        if (r_count == '0) begin
                            n_conf = '0;
                        end
                    end
                end else if (r_row.acquired && (r_row.owner != r_cmd.controller_entity)) begin
                    n_res.status = ST_ACQ_ELSEWHERE;
                end else begin
                    cmd_we            = 1'b1;
                    ram_wrow.acquired = 1'b1;
                    ram_wrow.owner    = r_cmd.controller_entity;
                end
            end
            OP_RELEASE: begin
                if (r_found && owned) begin
                    cmd_we            = 1'b1;
                    ram_wrow.acquired = 1'b0;
                    ram_wrow.locked   = 1'b0;
                    ram_wrow.owner    = '0;
                end else begin
                    n_res.status = ST_REL_REFUSED;
                end
            end
            OP_LOCK: begin
                if (!r_found) begin
                    n_res.status = ST_UNKNOWN;
                end else if (owned) begin
                    cmd_we          = 1'b1;
                    ram_wrow.locked = 1'b1;
                end else begin
                    n_res.status = ST_LOCK_REFUSED;
                end
            end
            OP_QUERY: begin
                if (r_found) begin
                    n_res.is_acquired = r_row.acquired;
                    n_res.is_locked   = r_row.locked;
                end
            end
            OP_GET_CONFIG: begin
                if (r_count != '0) begin
                    n_res.configuration = r_conf;
                end
            end
            OP_SET_CONFIG: begin
                if (r_count != '0) begin
                    n_conf              = r_cmd.config_value;
                    n_res.configuration = r_cmd.config_value;
                end else begin
                    n_res.status = ST_BAD_ARGS;
                end
            end
            default: begin
                n_res.status = ST_NOT_IMPL;
            end
        endcase
        ram_we = cmd_we && (r_state == S_EXEC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_conf      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_addr <= '0;
                    r_pend <= 1'b0;
                    if (take) begin
                        r_state <= i_q_cmd.needs_scan ? S_SCAN : S_EXEC;
                    end
                end
                S_SCAN: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (scan_done) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                    r_conf      <= n_conf;
                    if (add) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd   <= i_q_cmd;
            r_found <= 1'b0;
        end
        if (issue) begin
            r_pend_idx <= r_addr[IDX_W-1:0];
        end
        if (scan_hit) begin
            r_found   <= 1'b1;
            r_row     <= rd_row;
            r_hit_idx <= r_pend_idx;
        end
        if (r_state == S_EXEC) begin
            r_out <= n_res;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_res        = r_out;
    assign o_stat.exec  = (r_state == S_EXEC);
    assign o_stat.count = r_count;

endmodule

`default_nettype wire

// ===== design/entity_ownership_table_unit.sv =====
// Top level of the entity ownership table: stream ports, front end, back end, checks.
//
// The block keeps a table of up to TABLE_ENTRIES (64) entity IDs, each with an
// acquired mark, a locked mark and a 64-bit owner controller ID, and answers
// every command word with exactly one result word. Acquire, release, lock and
// query look the target up by a linear scan of the entry RAM, one entry per
// cycle over its single read port; a lookup that finds no match reads every
// entry in the table. Get config, set config and unknown opcodes skip the
// scan. Entries are appended in order and never removed, and only entries
// below the fill count are ever read, so the RAM needs no clearing pass after
// reset. A two-word command queue sits in front of the scanner, so new words
// are taken while a command is being worked on or while a finished result
// word waits for the downstream side.
`timescale 1ns / 1ps
`default_nettype none

`include "entity_ownership_table_unit_assert.svh"

module entity_ownership_table_unit import eot_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // Command words
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [63:0] target_entity, [127:64] controller_entity, [143:128] config_value
    input  logic [IN_DATA_W-1:0]   i_s_axis_tdata,
    // [2:0] operation
    input  logic [OP_W-1:0]        i_s_axis_tuser,

    // Result words
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [2:0] status, [3] is_acquired, [4] is_locked, [20:5] configuration,
    // [23:21] zero
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata
);

    // Queue head handed from the front end to the back end
    logic        q_valid;
    logic        q_ready;
    t_cmd        q_cmd;

    t_result     res;
    t_back_stat  back_stat;

    // Front end: decode the opcode, mark commands that need a table scan,
    // and hold them in the short queue.
    eot_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_q_valid       (q_valid),
        .o_q_cmd         (q_cmd),
        .i_q_ready       (q_ready)
    );

    // Back end: scan, update the matching or new row, register the result.
    eot_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_ready   (q_ready),
        .o_res_valid (o_m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (i_m_axis_tready),
        .o_stat      (back_stat)
    );

    // Pad the result fields up to a whole number of bytes
    assign o_m_axis_tdata = {(OUT_DATA_W - $bits(t_result))'(0), res};

    // The fill count never passes the table size
    `EOT_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1,
        back_stat.count <= CNT_W'(TABLE_ENTRIES),
        "entity count beyond table size")

    // The fill count only ever grows by one entry at a time
    `EOT_ASSERT_IMPL(a_count_step, i_clk, i_rst_n,
        back_stat.count != $past(back_stat.count),
        back_stat.count == CNT_W'($past(back_stat.count) + 1'b1),
        "entity count changed by other than one")

    // Every execute step leaves a result word behind
    `EOT_ASSERT_NEXT(a_exec_result, i_clk, i_rst_n, back_stat.exec, o_m_axis_tvalid,
        "execute step without result word")

    // A new result word only appears right after an execute step
    `EOT_ASSERT_IMPL(a_result_source, i_clk, i_rst_n, $rose(o_m_axis_tvalid),
        $past(back_stat.exec), "result word without execute step")

endmodule

`default_nettype wire

// ===== bench/entity_ownership_table_unit_monitor.sv =====
// Checker for the entity ownership table: predicts each result word and compares it.
`timescale 1ns / 1ps

module entity_ownership_table_unit_monitor import eot_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_tvalid,
    input  logic                   i_cmd_tready,
    input  logic [IN_DATA_W-1:0]   i_cmd_tdata,
    input  logic [OP_W-1:0]        i_cmd_tuser,
    input  logic                   i_res_tvalid,
    input  logic                   i_res_tready,
    input  logic [OUT_DATA_W-1:0]  i_res_tdata,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int RES_W = $bits(t_result);
    localparam int MAX_REPORTS = 10;

    // Shadow copy of the ownership table
    logic [ID_W-1:0]  row_id    [TABLE_ENTRIES];
    logic [ID_W-1:0]  row_owner [TABLE_ENTRIES];
    logic             row_acq   [TABLE_ENTRIES];
    logic             row_lck   [TABLE_ENTRIES];
    int               fill;
    logic [CFG_W-1:0] cur_cfg;

    t_result          expected_results [$];
    t_result          want_r;
    t_result          got_r;
    t_result          new_r;
    logic [OUT_DATA_W-RES_W-1:0] got_pad;
    int               errors;

    initial begin
        fill         = 0;
        cur_cfg      = '0;
        errors       = 0;
        o_fail_count = 0;
        o_pending    = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            row_id[i]    = '0;
            row_owner[i] = '0;
            row_acq[i]   = 1'b0;
            row_lck[i]   = 1'b0;
        end
    end

    function automatic int find_row(input logic [ID_W-1:0] id);
        for (int i = 0; i < fill; i++) begin
            if (row_id[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Apply one command to the shadow table and work out its result word
    task automatic apply_command(input logic [OP_W-1:0] op, input logic [ID_W-1:0] tgt,
                                 input logic [ID_W-1:0] ctl, input logic [CFG_W-1:0] cfg,
                                 output t_result res);
        int idx;
        res        = '0;
        res.status = ST_OK;
        idx        = find_row(tgt);
        case (op)
            OP_ACQUIRE: begin
                if (idx < 0 && fill >= TABLE_ENTRIES) begin
                    res.status = ST_ACQ_ELSEWHERE;
                end else begin
                    if (idx < 0) begin
                        idx            = fill;
                        row_id[idx]    = tgt;
                        row_acq[idx]   = 1'b0;
                        row_lck[idx]   = 1'b0;
                        row_owner[idx] = '0;
                        if (idx == 0) begin
                            cur_cfg = '0;
                        end
                        fill++;
                    end
                    if (row_acq[idx] && row_owner[idx] != ctl) begin
                        res.status = ST_ACQ_ELSEWHERE;
                    end else begin
                        row_acq[idx]   = 1'b1;
                        row_owner[idx] = ctl;
                    end
                end
            end
            OP_RELEASE: begin
                if (idx < 0) begin
                    res.status = ST_REL_REFUSED;
                end else if (!row_acq[idx] || row_owner[idx] != ctl) begin
                    res.status = ST_REL_REFUSED;
                end else begin
                    row_acq[idx]   = 1'b0;
                    row_lck[idx]   = 1'b0;
                    row_owner[idx] = '0;
                end
            end
            OP_LOCK: begin
                if (idx < 0) begin
                    res.status = ST_UNKNOWN;
                end else if (row_acq[idx] && row_owner[idx] == ctl) begin
                    row_lck[idx] = 1'b1;
                end else begin
                    res.status = ST_LOCK_REFUSED;
                end
            end
            OP_QUERY: begin
                if (idx >= 0) begin
                    res.is_acquired = row_acq[idx];
                    res.is_locked   = row_lck[idx];
                end
            end
            OP_GET_CONFIG: begin
                res.configuration = (fill > 0) ? cur_cfg : '0;
            end
            OP_SET_CONFIG: begin
                if (fill > 0) begin
                    cur_cfg           = cfg;
                    res.configuration = cfg;
                end else begin
                    res.status = ST_BAD_ARGS;
                end
            end
            default: begin
                res.status = ST_NOT_IMPL;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cmd_tvalid && i_cmd_tready) begin
                apply_command(i_cmd_tuser, i_cmd_tdata[ID_W-1:0],
                              i_cmd_tdata[2*ID_W-1:ID_W],
                              i_cmd_tdata[2*ID_W+CFG_W-1:2*ID_W], new_r);
                expected_results.push_back(new_r);
            end
            if (i_res_tvalid && i_res_tready) begin
                got_r   = i_res_tdata[RES_W-1:0];
                got_pad = i_res_tdata[OUT_DATA_W-1:RES_W];
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t: result word %h with no command pending",
                                 $realtime, i_res_tdata);
                    end
                end else begin
                    want_r = expected_results.pop_front();
                    if (got_r.status !== want_r.status ||
                        got_r.is_acquired !== want_r.is_acquired ||
                        got_r.is_locked !== want_r.is_locked ||
                        got_r.configuration !== want_r.configuration ||
                        got_pad !== '0) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display("%0t: mismatch: expected status %0d acq %0b lck %0b ",
                                     $realtime, want_r.status, want_r.is_acquired,
                                     want_r.is_locked,
                                     "cfg %h pad 0, got status %0d acq %0b lck %0b ",
                                     want_r.configuration,
                                     got_r.status, got_r.is_acquired, got_r.is_locked,
                                     "cfg %h pad %0h",
                                     got_r.configuration, got_pad);
                        end
                    end
                end
            end
        end
        o_fail_count <= errors;
        o_pending    <= expected_results.size();
    end

endmodule

// ===== bench/entity_ownership_table_unit_tb.sv =====
// Top of the entity ownership table bench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module entity_ownership_table_unit_tb;
    import eot_pkg::*;

    // Opcode outside the defined set; must answer not implemented
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    localparam logic [ID_W-1:0] CTRL_A = 64'h0123_4567_89AB_CDEF;
    localparam logic [ID_W-1:0] CTRL_B = 64'hFEDC_BA98_7654_3210;
    localparam logic [ID_W-1:0] ID_LOW  = '0;
    localparam logic [ID_W-1:0] ID_HIGH = '1;

    // Larger than the table so that it fills up and acquires start to bounce
    localparam int POOL_SIZE    = 80;
    localparam int RANDOM_WORDS = 1900;
    localparam int PHASES       = 4;
    // Headroom after the last result before the verdict
    localparam int DRAIN_CYCLES = 200;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  cmd_tvalid = 1'b0;
    logic                  cmd_tready;
    // [63:0] target_entity, [127:64] controller_entity, [143:128] config_value
    logic [IN_DATA_W-1:0]  cmd_tdata  = '0;
    // [2:0] operation
    logic [OP_W-1:0]       cmd_tuser  = OP_ACQUIRE;
    logic                  res_tvalid;
    logic                  res_tready = 1'b1;
    // [2:0] status, [3] is_acquired, [4] is_locked, [20:5] configuration, [23:21] zero
    logic [OUT_DATA_W-1:0] res_tdata;

    int fail_count;
    int pending;

    // Idle and stall odds in percent, changed per phase
    int idle_pct  = 0;
    int stall_pct = 0;
    int sent      = 0;

    logic [ID_W-1:0] entity_pool [POOL_SIZE];
    logic [ID_W-1:0] ctrl_pool   [4];

    entity_ownership_table_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (cmd_tvalid),
        .o_s_axis_tready (cmd_tready),
        .i_s_axis_tdata  (cmd_tdata),
        .i_s_axis_tuser  (cmd_tuser),
        .o_m_axis_tvalid (res_tvalid),
        .i_m_axis_tready (res_tready),
        .o_m_axis_tdata  (res_tdata)
    );

    entity_ownership_table_unit_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_tvalid (cmd_tvalid),
        .i_cmd_tready (cmd_tready),
        .i_cmd_tdata  (cmd_tdata),
        .i_cmd_tuser  (cmd_tuser),
        .i_res_tvalid (res_tvalid),
        .i_res_tready (res_tready),
        .i_res_tdata  (res_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Stall the result side per cycle at the current phase's odds
    always @(posedge i_clk) begin
        res_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [ID_W-1:0] rand_id();
        return {$urandom(), $urandom()};
    endfunction

    // Random configuration value over the full field range
    function automatic logic [CFG_W-1:0] rand_cfg();
        return CFG_W'($urandom_range(16'hFFFF));
    endfunction

    // Mostly known entities so lookups hit; now and then a fresh random ID
    function automatic logic [ID_W-1:0] pick_entity();
        if ($urandom_range(99) < 85) begin
            return entity_pool[$urandom_range(POOL_SIZE - 1)];
        end
        return rand_id();
    endfunction

    // A small set of controllers so that ownership checks often match
    function automatic logic [ID_W-1:0] pick_ctrl();
        if ($urandom_range(99) < 85) begin
            return ctrl_pool[$urandom_range(3)];
        end
        return rand_id();
    endfunction

    // Break a well-formed session now and then by swapping the caller
    function automatic logic [ID_W-1:0] maybe_other(input logic [ID_W-1:0] ctl);
        if ($urandom_range(99) < 15) begin
            return pick_ctrl();
        end
        return ctl;
    endfunction

    // Present one command word, hold it until taken, then maybe idle a while
    task automatic send_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] tgt,
                             input logic [ID_W-1:0] ctl, input logic [CFG_W-1:0] cfg);
        cmd_tvalid <= 1'b1;
        cmd_tuser  <= op;
        cmd_tdata  <= {cfg, ctl, tgt};
        @(posedge i_clk);
        while (!cmd_tready) begin
            @(posedge i_clk);
        end
        sent++;
        while ($urandom_range(99) < idle_pct) begin
            cmd_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Acquire, maybe lock, query, maybe touch the configuration, mostly release
    task automatic run_session();
        logic [ID_W-1:0] tgt;
        logic [ID_W-1:0] ctl;
        tgt = pick_entity();
        ctl = pick_ctrl();
        send_word(OP_ACQUIRE, tgt, maybe_other(ctl), rand_cfg());
        if ($urandom_range(1) == 1) begin
            send_word(OP_LOCK, tgt, maybe_other(ctl), rand_cfg());
        end
        send_word(OP_QUERY, tgt, pick_ctrl(), rand_cfg());
        if ($urandom_range(3) == 0) begin
            send_word(($urandom_range(1) == 1) ? OP_SET_CONFIG : OP_GET_CONFIG,
                      tgt, ctl, rand_cfg());
        end
        if ($urandom_range(3) != 0) begin
            send_word(OP_RELEASE, tgt, maybe_other(ctl), rand_cfg());
        end
    endtask

    // Noise: any opcode, including the unused ones, with arbitrary fields
    task automatic send_noise();
        send_word(OP_W'($urandom_range(7)), pick_entity(), pick_ctrl(), rand_cfg());
    endtask

    initial begin
        int phase_end;

        entity_pool[0] = ID_LOW;
        entity_pool[1] = ID_HIGH;
        for (int i = 2; i < POOL_SIZE; i++) begin
            entity_pool[i] = rand_id();
        end
        ctrl_pool[0] = CTRL_A;
        ctrl_pool[1] = CTRL_B;
        ctrl_pool[2] = '0;
        ctrl_pool[3] = '1;

        // Hold reset, then release it once
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table first
        send_word(OP_GET_CONFIG, ID_LOW, CTRL_A, 16'h1234);
        send_word(OP_SET_CONFIG, ID_LOW, CTRL_A, 16'hFFFF);
        send_word(OP_QUERY, ID_HIGH, CTRL_A, '0);
        send_word(OP_LOCK, ID_HIGH, CTRL_A, '0);
        send_word(OP_RELEASE, ID_HIGH, CTRL_A, '0);
        send_word(OP_OTHER, ID_HIGH, ID_HIGH, '1);
        send_word(OP_UNUSED, ID_HIGH, ID_HIGH, '1);
        // First entry: configuration, re-acquire, foreign acquire and lock
        send_word(OP_ACQUIRE, ID_LOW, CTRL_A, '1);
        send_word(OP_GET_CONFIG, ID_LOW, CTRL_A, '0);
        send_word(OP_SET_CONFIG, ID_LOW, CTRL_A, 16'hFFFF);
        send_word(OP_GET_CONFIG, ID_LOW, CTRL_B, '0);
        send_word(OP_ACQUIRE, ID_LOW, CTRL_A, '0);
        send_word(OP_ACQUIRE, ID_LOW, CTRL_B, '0);
        send_word(OP_LOCK, ID_LOW, CTRL_B, '0);
        send_word(OP_LOCK, ID_LOW, CTRL_A, '0);
        send_word(OP_QUERY, ID_LOW, CTRL_B, '0);
        send_word(OP_RELEASE, ID_LOW, CTRL_B, '0);
        send_word(OP_RELEASE, ID_LOW, CTRL_A, '0);
        send_word(OP_QUERY, ID_LOW, CTRL_A, '0);
        // Lock of an entity nobody holds
        send_word(OP_LOCK, ID_LOW, CTRL_A, '0);
        // Second entry at the top of the ID range
        send_word(OP_ACQUIRE, ID_HIGH, ID_HIGH, '0);
        send_word(OP_SET_CONFIG, ID_HIGH, ID_HIGH, '0);
        send_word(OP_QUERY, ID_HIGH, ID_LOW, '0);
        send_word(OP_RELEASE, ID_HIGH, ID_LOW, '0);

        // Random: mostly sessions, the rest noise; one idle and stall profile per phase
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 57;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 57;
                end
                default: begin
                    idle_pct  = 23;
                    stall_pct = 23;
                end
            endcase
            phase_end = sent + RANDOM_WORDS / PHASES;
            while (sent < phase_end) begin
                if ($urandom_range(99) < 65) begin
                    run_session();
                end else begin
                    send_noise();
                end
            end
        end

        // Drop valid, let the stall profile go quiet, then drain
        cmd_tvalid <= 1'b0;
        stall_pct = 0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Stop a hung run; well past the slowest legal run
    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/eot_pkg.sv
design/eot_ram.sv
design/eot_front.sv
design/eot_back.sv
design/entity_ownership_table_unit.sv
bench/entity_ownership_table_unit_monitor.sv
bench/entity_ownership_table_unit_tb.sv
